### design/dff_pkg.sv
// Shared constants, types and arithmetic helpers for the diffusive face flux block.
package dff_pkg;

    // Fixed-point format: signed Q(WORD_BITS-FRAC_BITS).FRAC_BITS words.
    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;

    // Non-negative quantities (densities, diffusivities, spacings) use one bit less.
    localparam int POS_W  = WORD_BITS - 1;
    localparam int SEL_W  = 2;
    localparam int PROD_W = POS_W + WORD_BITS;

    // Boundary numerator 9*here - 8*below - above needs five extra bits.
    localparam int NUM_W       = WORD_BITS + 5;
    localparam int DIV_DIGITS  = (NUM_W - 1 + 3) / 4;
    localparam int DIV_W       = 4 * DIV_DIGITS;
    localparam int DIV_HI_DIGS = (DIV_DIGITS + 1) / 2;
    localparam int DIV_LO_DIGS = DIV_DIGITS - DIV_HI_DIGS;

    // Division of a six-bit partial remainder by three: v * 43 >> 7 is exact below 48.
    localparam int DIV3_RECIP = 43;
    localparam int DIV3_SHIFT = 7;
    localparam int DIV3_PW    = 13;

    localparam logic [WORD_BITS-1:0] WMAX     = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] WMIN_MAG = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic [POS_W-1:0]     ONE_Q    = POS_W'(1) << FRAC_BITS;

    localparam int REG_IDX_W = 3;

    typedef enum logic [SEL_W-1:0] {
        DIR_X = 2'd0,
        DIR_Y = 2'd1,
        DIR_Z = 2'd2
    } dff_dir_e;

    typedef enum logic [SEL_W-1:0] {
        CLS_THETA  = 2'd0,
        CLS_SCALAR = 2'd1,
        CLS_TKE    = 2'd2
    } dff_cls_e;

    typedef enum logic [SEL_W-1:0] {
        BND_INTERIOR = 2'd0,
        BND_LOW      = 2'd1,
        BND_HIGH     = 2'd2
    } dff_bnd_e;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_DENSITY_MODE  = 3'd0,
        REG_TURBULENCE_ON = 3'd1,
        REG_ALPHA_THETA   = 3'd2,
        REG_ALPHA_SCALAR  = 3'd3,
        REG_INV_DX        = 3'd4,
        REG_INV_DY        = 3'd5,
        REG_INV_DZ        = 3'd6
    } dff_reg_e;

    typedef struct packed {
        logic             density_mode;
        logic             turbulence_on;
        logic [POS_W-1:0] alpha_theta;
        logic [POS_W-1:0] alpha_scalar;
        logic [POS_W-1:0] inv_dx;
        logic [POS_W-1:0] inv_dy;
        logic [POS_W-1:0] inv_dz;
    } dff_cfg_t;

    // Item handed from the coefficient front end to the multiplier chain.
    typedef struct packed {
        logic [POS_W-1:0]     alpha;
        logic [WORD_BITS-1:0] mag;
        logic                 neg;
        logic                 sat;
        logic [POS_W-1:0]     inv;
        logic [POS_W-1:0]     mapf;
        logic                 is_xy;
    } dff_mid_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] mag;
        logic                 sat;
    } dff_clip_t;

    // Drops the fraction bits of a non-negative product and clips it to lim.
    function automatic dff_clip_t clip_shift(input logic [PROD_W-1:0] prod,
                                             input logic [WORD_BITS-1:0] lim);
        logic [PROD_W-FRAC_BITS-1:0] r;
        dff_clip_t res;
        r = prod[PROD_W-1:FRAC_BITS];
        res.sat = (r > (PROD_W-FRAC_BITS)'(lim));
        res.mag = res.sat ? lim : r[WORD_BITS-1:0];
        return res;
    endfunction

    // One radix-16 long-division step by three: returns {quotient digit, remainder}.
    function automatic logic [5:0] div3_nibble(input logic [1:0] rem, input logic [3:0] nib);
        logic [5:0]         v;
        logic [DIV3_PW-1:0] p;
        logic [3:0]         q;
        logic [5:0]         q3;
        v  = {rem, nib};
        p  = DIV3_PW'(v) * DIV3_PW'(DIV3_RECIP);
        q  = 4'(p >> DIV3_SHIFT);
        q3 = 6'(q) * 6'd3;
        return {q, 2'(v - q3)};
    endfunction

endpackage

### design/dff_ifs.sv
// Valid/ready channel interfaces for face items and flux results.
interface dff_face_if;
    import dff_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [SEL_W-1:0]            direction;
    logic [SEL_W-1:0]            quantity_class;
    logic [SEL_W-1:0]            boundary_case;
    logic signed [WORD_BITS-1:0] prim_below;
    logic signed [WORD_BITS-1:0] prim_here;
    logic signed [WORD_BITS-1:0] prim_above;
    logic [POS_W-1:0]            rho_below;
    logic [POS_W-1:0]            rho_here;
    logic [POS_W-1:0]            mu_below;
    logic [POS_W-1:0]            mu_here;
    logic [POS_W-1:0]            map_factor;

    modport source (
        output valid, direction, quantity_class, boundary_case, prim_below, prim_here,
               prim_above, rho_below, rho_here, mu_below, mu_here, map_factor,
        input  ready
    );

    modport sink (
        input  valid, direction, quantity_class, boundary_case, prim_below, prim_here,
               prim_above, rho_below, rho_here, mu_below, mu_here, map_factor,
        output ready
    );
endinterface

interface dff_flux_if;
    import dff_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] flux;
    logic                        saturated;

    modport source (
        output valid, flux, saturated,
        input  ready
    );

    modport sink (
        input  valid, flux, saturated,
        output ready
    );
endinterface

### design/dff_cfg.sv
// Configuration register file with a plain write port.
module dff_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [dff_pkg::REG_IDX_W-1:0]    index,
    input  logic [dff_pkg::POS_W-1:0]        wdata,
    output dff_pkg::dff_cfg_t                cfg
);
    import dff_pkg::*;

    dff_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.density_mode  <= 1'b0;
            cfg_reg.turbulence_on <= 1'b0;
            cfg_reg.alpha_theta   <= '0;
            cfg_reg.alpha_scalar  <= '0;
            cfg_reg.inv_dx        <= ONE_Q;
            cfg_reg.inv_dy        <= ONE_Q;
            cfg_reg.inv_dz        <= ONE_Q;
        end
        else if (wr_en)
        begin
            case (index)
                REG_DENSITY_MODE:  cfg_reg.density_mode  <= wdata[0];
                REG_TURBULENCE_ON: cfg_reg.turbulence_on <= wdata[0];
                REG_ALPHA_THETA:   cfg_reg.alpha_theta   <= wdata;
                REG_ALPHA_SCALAR:  cfg_reg.alpha_scalar  <= wdata;
                REG_INV_DX:        cfg_reg.inv_dx        <= wdata;
                REG_INV_DY:        cfg_reg.inv_dy        <= wdata;
                REG_INV_DZ:        cfg_reg.inv_dz        <= wdata;
                default:           ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/dff_front.sv
// Front end: effective diffusivity and clipped face difference, four pipeline stages.
module dff_front (
    input  logic               clk,
    input  logic               rst_n,
    input  dff_pkg::dff_cfg_t  cfg,
    dff_face_if.sink           face,
    output logic               mid_valid,
    input  logic               mid_ready,
    output dff_pkg::dff_mid_t  mid
);
    import dff_pkg::*;

    localparam int NST    = 4;
    localparam int DIFF_W = WORD_BITS + 1;
    localparam int XHI_W  = 4 * DIV_HI_DIGS;
    localparam int XLO_W  = 4 * DIV_LO_DIGS;

    typedef struct packed {
        logic [POS_W-1:0]     inv;
        logic [POS_W-1:0]     mapf;
        logic                 is_xy;
        logic                 use_bnd;
        logic                 sign;
        logic [WORD_BITS-1:0] dmag;
        logic                 dneg;
        logic                 dsat;
    } front_side_t;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] adv;

    // Stage 1 registers
    front_side_t             s1_side_reg, s1_side_next;
    logic [POS_W-1:0]        s1_avg_rho_reg, s1_avg_rho_next;
    logic [POS_W-1:0]        s1_avg_mu_reg, s1_avg_mu_next;
    logic [POS_W-1:0]        s1_alpha_reg, s1_alpha_next;
    logic signed [NUM_W-1:0] s1_num_reg, s1_num_next;

    // Stage 2 registers
    front_side_t             s2_side_reg;
    logic [PROD_W-1:0]       s2_dens_reg, s2_dens_next;
    logic [POS_W-1:0]        s2_alpha_reg;
    logic [POS_W-1:0]        s2_avg_mu_reg;
    logic [DIV_W-1:0]        s2_x_reg, s2_x_next;

    // Stage 3 registers
    front_side_t             s3_side_reg;
    logic [POS_W-1:0]        s3_alpha_reg, s3_alpha_next;
    logic                    s3_asat_reg, s3_asat_next;
    logic [XHI_W-1:0]        s3_qhi_reg, s3_qhi_next;
    logic [1:0]              s3_rem_reg, s3_rem_next;
    logic [XLO_W-1:0]        s3_xlo_reg;

    // Stage 4 register
    dff_mid_t                s4_mid_reg, s4_mid_next;

    // Ready ripples back: a stage advances when it is empty or the next one advances.
    always_comb
    begin
        adv[NST-1] = !v_reg[NST-1] || mid_ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign face.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= face.valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Stage 1: averages, coefficient selection, boundary numerator, interior difference.
    logic [POS_W:0]           rho_sum;
    logic [POS_W:0]           mu_sum;
    logic signed [NUM_W-1:0]  here_x;
    logic signed [NUM_W-1:0]  below_x;
    logic signed [NUM_W-1:0]  above_x;
    logic signed [DIFF_W-1:0] d_int;
    logic signed [DIFF_W-1:0] d_neg;
    logic                     d_hi_sat;
    logic                     d_lo_sat;

    always_comb
    begin
        rho_sum         = {1'b0, face.rho_below} + {1'b0, face.rho_here};
        mu_sum          = {1'b0, face.mu_below} + {1'b0, face.mu_here};
        s1_avg_rho_next = rho_sum[POS_W:1];
        s1_avg_mu_next  = mu_sum[POS_W:1];

        case (face.quantity_class)
            CLS_THETA:  s1_alpha_next = cfg.alpha_theta;
            CLS_SCALAR: s1_alpha_next = cfg.alpha_scalar;
            default:    s1_alpha_next = '0;
        endcase

        case (face.direction)
            DIR_X:   s1_side_next.inv = cfg.inv_dx;
            DIR_Y:   s1_side_next.inv = cfg.inv_dy;
            default: s1_side_next.inv = cfg.inv_dz;
        endcase

        s1_side_next.mapf    = face.map_factor;
        s1_side_next.is_xy   = face.direction inside {DIR_X, DIR_Y};
        s1_side_next.use_bnd = !s1_side_next.is_xy &&
                               (face.boundary_case inside {BND_LOW, BND_HIGH});

        here_x      = NUM_W'(face.prim_here);
        below_x     = NUM_W'(face.prim_below);
        above_x     = NUM_W'(face.prim_above);
        s1_num_next = (here_x <<< 3) + here_x - (below_x <<< 3) - above_x;
        // The high face takes the negated stencil.
        s1_side_next.sign = s1_num_next[NUM_W-1] ^ (face.boundary_case == BND_HIGH);

        d_int    = DIFF_W'(face.prim_here) - DIFF_W'(face.prim_below);
        d_neg    = -d_int;
        d_hi_sat = !d_int[DIFF_W-1] && d_int[DIFF_W-2];
        d_lo_sat = d_int[DIFF_W-1] && !d_int[DIFF_W-2];
        s1_side_next.dneg = d_int[DIFF_W-1];
        s1_side_next.dsat = d_hi_sat || d_lo_sat;
        if (d_lo_sat)
        begin
            s1_side_next.dmag = WMIN_MAG;
        end
        else if (d_hi_sat)
        begin
            s1_side_next.dmag = WMAX;
        end
        else if (d_int[DIFF_W-1])
        begin
            s1_side_next.dmag = d_neg[WORD_BITS-1:0];
        end
        else
        begin
            s1_side_next.dmag = d_int[WORD_BITS-1:0];
        end
    end

    // Stage 2: density product and the dividend |num| + 1 for the rounded division.
    logic signed [NUM_W-1:0] num_abs;

    always_comb
    begin
        s2_dens_next = PROD_W'(s1_avg_rho_reg) * PROD_W'(s1_alpha_reg);
        num_abs      = s1_num_reg[NUM_W-1] ? -s1_num_reg : s1_num_reg;
        s2_x_next    = DIV_W'(num_abs[NUM_W-2:0]) + DIV_W'(1);
    end

    // Stage 3: diffusivity clip and eddy term; upper quotient digits.
    dff_clip_t              dens_clip;
    logic [WORD_BITS-1:0]   alpha_a;
    logic [WORD_BITS:0]     alpha_sum;
    logic                   sat_a;
    logic [5:0]             hi_step;
    logic [1:0]             hi_rem;

    always_comb
    begin
        dens_clip = clip_shift(s2_dens_reg, WMAX);
        if (cfg.density_mode)
        begin
            alpha_a = dens_clip.mag;
            sat_a   = dens_clip.sat;
        end
        else
        begin
            alpha_a = WORD_BITS'(s2_alpha_reg);
            sat_a   = 1'b0;
        end

        alpha_sum = (WORD_BITS+1)'(alpha_a) + (WORD_BITS+1)'(s2_avg_mu_reg);
        if (cfg.turbulence_on)
        begin
            if (alpha_sum > (WORD_BITS+1)'(WMAX))
            begin
                alpha_a = WMAX;
                sat_a   = 1'b1;
            end
            else
            begin
                alpha_a = alpha_sum[WORD_BITS-1:0];
            end
        end
        s3_alpha_next = alpha_a[POS_W-1:0];
        s3_asat_next  = sat_a;

        hi_rem      = 2'd0;
        hi_step     = '0;
        s3_qhi_next = '0;
        for (int i = 0; i < DIV_HI_DIGS; i++)
        begin
            hi_step = div3_nibble(hi_rem, s2_x_reg[DIV_W-1-4*i -: 4]);
            s3_qhi_next[XHI_W-1-4*i -: 4] = hi_step[5:2];
            hi_rem = hi_step[1:0];
        end
        s3_rem_next = hi_rem;
    end

    // Stage 4: lower quotient digits, sign and clip of the difference.
    logic [5:0]       lo_step;
    logic [1:0]       lo_rem;
    logic [XLO_W-1:0] q_lo;
    logic [DIV_W-1:0] q_all;

    always_comb
    begin
        lo_rem  = s3_rem_reg;
        lo_step = '0;
        q_lo    = '0;
        for (int i = 0; i < DIV_LO_DIGS; i++)
        begin
            lo_step = div3_nibble(lo_rem, s3_xlo_reg[XLO_W-1-4*i -: 4]);
            q_lo[XLO_W-1-4*i -: 4] = lo_step[5:2];
            lo_rem = lo_step[1:0];
        end
        q_all = {s3_qhi_reg, q_lo};

        s4_mid_next.alpha = s3_alpha_reg;
        s4_mid_next.inv   = s3_side_reg.inv;
        s4_mid_next.mapf  = s3_side_reg.mapf;
        s4_mid_next.is_xy = s3_side_reg.is_xy;

        if (!s3_side_reg.use_bnd)
        begin
            s4_mid_next.mag = s3_side_reg.dmag;
            s4_mid_next.neg = s3_side_reg.dneg;
            s4_mid_next.sat = s3_asat_reg || s3_side_reg.dsat;
        end
        else if (s3_side_reg.sign)
        begin
            // A zero quotient is a positive zero.
            s4_mid_next.neg = (q_all != '0);
            if (q_all > DIV_W'(WMIN_MAG))
            begin
                s4_mid_next.mag = WMIN_MAG;
                s4_mid_next.sat = 1'b1;
            end
            else
            begin
                s4_mid_next.mag = q_all[WORD_BITS-1:0];
                s4_mid_next.sat = s3_asat_reg;
            end
        end
        else
        begin
            s4_mid_next.neg = 1'b0;
            if (q_all > DIV_W'(WMAX))
            begin
                s4_mid_next.mag = WMAX;
                s4_mid_next.sat = 1'b1;
            end
            else
            begin
                s4_mid_next.mag = q_all[WORD_BITS-1:0];
                s4_mid_next.sat = s3_asat_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_side_reg    <= s1_side_next;
            s1_avg_rho_reg <= s1_avg_rho_next;
            s1_avg_mu_reg  <= s1_avg_mu_next;
            s1_alpha_reg   <= s1_alpha_next;
            s1_num_reg     <= s1_num_next;
        end
        if (adv[1])
        begin
            s2_side_reg   <= s1_side_reg;
            s2_dens_reg   <= s2_dens_next;
            s2_alpha_reg  <= s1_alpha_reg;
            s2_avg_mu_reg <= s1_avg_mu_reg;
            s2_x_reg      <= s2_x_next;
        end
        if (adv[2])
        begin
            s3_side_reg  <= s2_side_reg;
            s3_alpha_reg <= s3_alpha_next;
            s3_asat_reg  <= s3_asat_next;
            s3_qhi_reg   <= s3_qhi_next;
            s3_rem_reg   <= s3_rem_next;
            s3_xlo_reg   <= s2_x_reg[XLO_W-1:0];
        end
        if (adv[3])
        begin
            s4_mid_reg <= s4_mid_next;
        end
    end

    assign mid_valid = v_reg[NST-1];
    assign mid       = s4_mid_reg;

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        face.valid && face.ready |=> v_reg[0])
        else $error("accepted face transaction did not enter the first stage");

    a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NST-1] && !mid_ready |=> v_reg[NST-1] && $stable(s4_mid_reg))
        else $error("stalled front-end item changed or vanished");

    a_neg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        mid_valid && mid.neg |-> mid.mag != '0)
        else $error("negative difference with zero magnitude");
`endif

endmodule

### design/dff_chain.sv
// Multiplier chain: diffusivity, inverse spacing and map factor products with clipping.
module dff_chain (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               mid_valid,
    output logic               mid_ready,
    input  dff_pkg::dff_mid_t  mid,
    dff_flux_if.source         result
);
    import dff_pkg::*;

    localparam int NST = 4;

    typedef struct packed {
        logic             neg;
        logic             sat;
        logic [POS_W-1:0] inv;
        logic [POS_W-1:0] mapf;
        logic             is_xy;
    } chain_side_t;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] adv;

    chain_side_t                 c1_side_reg, c1_side_next;
    logic [PROD_W-1:0]           c1_prod_reg, c1_prod_next;
    chain_side_t                 c2_side_reg, c2_side_next;
    logic [PROD_W-1:0]           c2_prod_reg, c2_prod_next;
    chain_side_t                 c3_side_reg, c3_side_next;
    logic [PROD_W-1:0]           c3_prod_reg, c3_prod_next;
    logic [WORD_BITS-1:0]        c3_mag_reg, c3_mag_next;
    logic signed [WORD_BITS-1:0] flux_reg, flux_next;
    logic                        sat_reg, sat_next;

    always_comb
    begin
        adv[NST-1] = !v_reg[NST-1] || result.ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign mid_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= mid_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // A negative result may reach one step further than a positive one.
    function automatic logic [WORD_BITS-1:0] mag_limit(input logic neg);
        return neg ? WMIN_MAG : WMAX;
    endfunction

    dff_clip_t clip1;
    dff_clip_t clip2;
    dff_clip_t clip3;
    logic [WORD_BITS-1:0] mag_final;

    always_comb
    begin
        c1_side_next.neg   = mid.neg;
        c1_side_next.sat   = mid.sat;
        c1_side_next.inv   = mid.inv;
        c1_side_next.mapf  = mid.mapf;
        c1_side_next.is_xy = mid.is_xy;
        c1_prod_next       = PROD_W'(mid.alpha) * PROD_W'(mid.mag);

        clip1            = clip_shift(c1_prod_reg, mag_limit(c1_side_reg.neg));
        c2_side_next     = c1_side_reg;
        c2_side_next.sat = c1_side_reg.sat || clip1.sat;
        c2_prod_next     = PROD_W'(clip1.mag) * PROD_W'(c1_side_reg.inv);

        clip2            = clip_shift(c2_prod_reg, mag_limit(c2_side_reg.neg));
        c3_side_next     = c2_side_reg;
        c3_side_next.sat = c2_side_reg.sat || clip2.sat;
        c3_mag_next      = clip2.mag;
        c3_prod_next     = PROD_W'(clip2.mag) * PROD_W'(c2_side_reg.mapf);

        // The map factor applies to horizontal faces only.
        clip3     = clip_shift(c3_prod_reg, mag_limit(c3_side_reg.neg));
        mag_final = c3_side_reg.is_xy ? clip3.mag : c3_mag_reg;
        sat_next  = c3_side_reg.sat || (c3_side_reg.is_xy && clip3.sat);
        flux_next = c3_side_reg.neg ? -$signed(mag_final) : $signed(mag_final);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            c1_side_reg <= c1_side_next;
            c1_prod_reg <= c1_prod_next;
        end
        if (adv[1])
        begin
            c2_side_reg <= c2_side_next;
            c2_prod_reg <= c2_prod_next;
        end
        if (adv[2])
        begin
            c3_side_reg <= c3_side_next;
            c3_prod_reg <= c3_prod_next;
            c3_mag_reg  <= c3_mag_next;
        end
        if (adv[3])
        begin
            flux_reg <= flux_next;
            sat_reg  <= sat_next;
        end
    end

    assign result.valid     = v_reg[NST-1];
    assign result.flux      = flux_reg;
    assign result.saturated = sat_reg;

`ifndef SYNTHESIS
    a_c1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] && !adv[0] |=> v_reg[0] && $stable(c1_prod_reg))
        else $error("stalled first product changed or vanished");

    a_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NST-2] && adv[NST-1] |=> v_reg[NST-1])
        else $error("item in last product stage did not reach the output register");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid && $stable(result.flux)
            && $stable(result.saturated))
        else $error("stalled result transaction changed or vanished");
`endif

endmodule

### design/diffusive_face_flux.sv
// Top level of the diffusive face flux pipeline.
//
//  Channel    Kind               Direction  Contents
//  face       valid/ready        in         one cell face per transaction
//  result     valid/ready        out        flux and saturation flag per transaction
//  cfg_*      write enable port  in         register index and write data
//
// One face enters per cycle while the pipeline is not stalled. An accepted face passes
// through four stages in the coefficient front end and four in the multiplier chain
// before result.valid rises.
// One 31x32 multiply or a group of radix-16 division-by-three steps sets a stage's depth.
// Reset empties the pipeline and loads the configuration registers with their reset values.
// A stalled output holds the last stage; earlier stages keep advancing into empty slots.
module diffusive_face_flux (
    input  logic                          clk,
    input  logic                          rst_n,
    dff_face_if.sink                      face,
    dff_flux_if.source                    result,
    input  logic                          cfg_wr_en,
    input  logic [dff_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [dff_pkg::POS_W-1:0]     cfg_wdata
);
    import dff_pkg::*;

    dff_cfg_t cfg;
    dff_mid_t mid;
    logic     mid_valid;
    logic     mid_ready;

    dff_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg_wr_en),
        .index (cfg_index),
        .wdata (cfg_wdata),
        .cfg   (cfg)
    );

    dff_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .face      (face),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid       (mid)
    );

    dff_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid       (mid),
        .result    (result)
    );

endmodule

### tb/diffusive_face_flux_tb.sv
// Self-checking testbench for the diffusive face flux pipeline.
`timescale 1ns / 100ps

module diffusive_face_flux_tb;
    import dff_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASES         = 9;
    localparam int FACES_PER_PHASE = 150;
    // Selector code outside every named set, handled as an open case by the block.
    localparam logic [SEL_W-1:0] SEL_UNUSED = 2'd3;

    typedef struct {
        logic [SEL_W-1:0]            direction;
        logic [SEL_W-1:0]            quantity_class;
        logic [SEL_W-1:0]            boundary_case;
        logic signed [WORD_BITS-1:0] prim_below;
        logic signed [WORD_BITS-1:0] prim_here;
        logic signed [WORD_BITS-1:0] prim_above;
        logic [POS_W-1:0]            rho_below;
        logic [POS_W-1:0]            rho_here;
        logic [POS_W-1:0]            mu_below;
        logic [POS_W-1:0]            mu_here;
        logic [POS_W-1:0]            map_factor;
    } face_t;

    typedef struct {
        logic signed [WORD_BITS-1:0] flux;
        logic                        saturated;
    } flux_t;

    typedef struct packed {
        logic        clip;
        logic [63:0] value;
    } scaled_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [POS_W-1:0]     cfg_wdata;

    dff_face_if face_ch ();
    dff_flux_if flux_ch ();

    diffusive_face_flux dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .face      (face_ch),
        .result    (flux_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    dff_cfg_t    coeffs;
    face_t       faces_pending[$];
    flux_t       flux_expected[$];
    face_t       face_on_bus;
    bit          sender_calm;
    bit          receiver_calm;
    int unsigned send_gap;
    int unsigned recv_stall;
    int unsigned mismatches;
    int unsigned quiet_cycles;

    function automatic int unsigned draw_idle(bit calm);
        return calm ? 0 : $urandom_range(7, 0);
    endfunction

    // Full product, fraction bits dropped toward zero, clipped to lim.
    function automatic scaled_t scale_q(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
        logic [63:0] prod;
        scaled_t     s;
        prod = a * b;
        s.value = prod >> FRAC_BITS;
        s.clip = s.value > lim;
        if (s.clip)
            s.value = lim;
        return s;
    endfunction

    function automatic flux_t face_flux(face_t f);
        longint      wmax;
        longint      below;
        longint      here;
        longint      above;
        longint      num;
        longint      diff;
        logic [63:0] diffusivity;
        logic [63:0] mag;
        logic [63:0] lim;
        logic [63:0] inv;
        logic        is_z;
        logic        neg;
        logic        clipped;
        scaled_t     s;
        flux_t       r;
        wmax = (longint'(1) <<< (WORD_BITS - 1)) - 1;
        clipped = 1'b0;
        is_z = (f.direction != DIR_X) && (f.direction != DIR_Y);

        case (f.quantity_class)
            CLS_THETA:  diffusivity = 64'(coeffs.alpha_theta);
            CLS_SCALAR: diffusivity = 64'(coeffs.alpha_scalar);
            default:    diffusivity = 64'd0;
        endcase
        if (coeffs.density_mode)
        begin
            s = scale_q((64'(f.rho_below) + 64'(f.rho_here)) >> 1, diffusivity, 64'(wmax));
            diffusivity = s.value;
            clipped |= s.clip;
        end
        if (coeffs.turbulence_on)
        begin
            diffusivity += (64'(f.mu_below) + 64'(f.mu_here)) >> 1;
            if (diffusivity > 64'(wmax))
            begin
                diffusivity = 64'(wmax);
                clipped = 1'b1;
            end
        end

        below = longint'(f.prim_below);
        here  = longint'(f.prim_here);
        above = longint'(f.prim_above);
        if (is_z && (f.boundary_case == BND_LOW || f.boundary_case == BND_HIGH))
        begin
            // One-sided stencil over three cells; the third is rounded to nearest.
            num  = 9 * here - 8 * below - above;
            diff = (num >= 0) ? (num + 1) / 3 : -((1 - num) / 3);
            if (f.boundary_case == BND_HIGH)
                diff = -diff;
        end
        else
            diff = here - below;
        if (diff > wmax)
        begin
            diff = wmax;
            clipped = 1'b1;
        end
        else if (diff < -wmax - 1)
        begin
            diff = -wmax - 1;
            clipped = 1'b1;
        end

        neg = diff < 0;
        mag = neg ? 64'(-diff) : 64'(diff);
        lim = neg ? 64'(wmax) + 64'd1 : 64'(wmax);
        case (f.direction)
            DIR_X:   inv = 64'(coeffs.inv_dx);
            DIR_Y:   inv = 64'(coeffs.inv_dy);
            default: inv = 64'(coeffs.inv_dz);
        endcase

        s = scale_q(diffusivity, mag, lim);
        mag = s.value;
        clipped |= s.clip;
        s = scale_q(mag, inv, lim);
        mag = s.value;
        clipped |= s.clip;
        if (!is_z)
        begin
            s = scale_q(mag, 64'(f.map_factor), lim);
            mag = s.value;
            clipped |= s.clip;
        end

        r.flux = neg ? WORD_BITS'(-mag) : WORD_BITS'(mag);
        r.saturated = clipped;
        return r;
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        int unsigned pick;
        int unsigned width;
        pick = $urandom_range(19, 0);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return {POS_W{1'b1}};
        if (pick == 2)
            return ONE_Q;
        width = (pick < 7) ? $urandom_range(POS_W, 1) : $urandom_range(22, 8);
        return POS_W'($urandom) & POS_W'((64'd1 << width) - 64'd1);
    endfunction

    function automatic logic signed [WORD_BITS-1:0] pick_prim();
        int unsigned             pick;
        int unsigned             width;
        logic [WORD_BITS-1:0]    v;
        pick = $urandom_range(19, 0);
        if (pick == 0)
            return WMAX;
        if (pick == 1)
            return WMIN_MAG;
        if (pick == 2)
            return '0;
        width = (pick < 7) ? $urandom_range(WORD_BITS, 1) : $urandom_range(24, 8);
        v = WORD_BITS'($urandom) & WORD_BITS'((64'd1 << width) - 64'd1);
        if ($urandom_range(1, 0) == 1)
            v = -v;
        return v;
    endfunction

    function automatic logic [SEL_W-1:0] pick_sel();
        return ($urandom_range(9, 0) == 0) ? SEL_UNUSED : SEL_W'($urandom_range(2, 0));
    endfunction

    function automatic face_t random_face();
        face_t f;
        f.direction      = pick_sel();
        f.quantity_class = pick_sel();
        f.boundary_case  = pick_sel();
        f.prim_below     = pick_prim();
        // Half the time neighboring cells hold similar values, which keeps many fluxes in range.
        if ($urandom_range(1, 0) == 1)
        begin
            f.prim_here  = f.prim_below + WORD_BITS'($signed(16'($urandom)));
            f.prim_above = f.prim_here + WORD_BITS'($signed(16'($urandom)));
        end
        else
        begin
            f.prim_here  = pick_prim();
            f.prim_above = pick_prim();
        end
        f.rho_below  = pick_pos();
        f.rho_here   = pick_pos();
        f.mu_below   = pick_pos();
        f.mu_here    = pick_pos();
        f.map_factor = pick_pos();
        return f;
    endfunction

    function automatic void add_face(logic [SEL_W-1:0] dir, logic [SEL_W-1:0] cls,
                                     logic [SEL_W-1:0] bnd,
                                     logic signed [WORD_BITS-1:0] below,
                                     logic signed [WORD_BITS-1:0] here,
                                     logic signed [WORD_BITS-1:0] above,
                                     logic [POS_W-1:0] rho_b, logic [POS_W-1:0] rho_h,
                                     logic [POS_W-1:0] mu_b, logic [POS_W-1:0] mu_h,
                                     logic [POS_W-1:0] mapf);
        face_t f;
        f.direction      = dir;
        f.quantity_class = cls;
        f.boundary_case  = bnd;
        f.prim_below     = below;
        f.prim_here      = here;
        f.prim_above     = above;
        f.rho_below      = rho_b;
        f.rho_here       = rho_h;
        f.mu_below       = mu_b;
        f.mu_here        = mu_h;
        f.map_factor     = mapf;
        faces_pending.push_back(f);
    endfunction

    task automatic write_reg(dff_reg_e idx, logic [POS_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_DENSITY_MODE:  coeffs.density_mode  = value[0];
            REG_TURBULENCE_ON: coeffs.turbulence_on = value[0];
            REG_ALPHA_THETA:   coeffs.alpha_theta   = value;
            REG_ALPHA_SCALAR:  coeffs.alpha_scalar  = value;
            REG_INV_DX:        coeffs.inv_dx        = value;
            REG_INV_DY:        coeffs.inv_dy        = value;
            REG_INV_DZ:        coeffs.inv_dz        = value;
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_coeffs(logic dm, logic turb, logic [POS_W-1:0] a_theta,
                               logic [POS_W-1:0] a_scalar, logic [POS_W-1:0] ix,
                               logic [POS_W-1:0] iy, logic [POS_W-1:0] iz);
        write_reg(REG_DENSITY_MODE, POS_W'(dm));
        write_reg(REG_TURBULENCE_ON, POS_W'(turb));
        write_reg(REG_ALPHA_THETA, a_theta);
        write_reg(REG_ALPHA_SCALAR, a_scalar);
        write_reg(REG_INV_DX, ix);
        write_reg(REG_INV_DY, iy);
        write_reg(REG_INV_DZ, iz);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (faces_pending.size() != 0 || face_ch.valid || flux_expected.size() != 0)
            @(negedge clk);
    endtask

    // Face driver: one transaction at a time, with a random gap after each face.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_ch.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (face_ch.valid && face_ch.ready)
                flux_expected.push_back(face_flux(face_on_bus));
            if (!face_ch.valid || face_ch.ready)
            begin
                if (send_gap > 0 || faces_pending.size() == 0)
                begin
                    if (send_gap > 0)
                        send_gap--;
                    face_ch.valid <= 1'b0;
                end
                else
                begin
                    face_on_bus = faces_pending.pop_front();
                    face_ch.direction      <= face_on_bus.direction;
                    face_ch.quantity_class <= face_on_bus.quantity_class;
                    face_ch.boundary_case  <= face_on_bus.boundary_case;
                    face_ch.prim_below     <= face_on_bus.prim_below;
                    face_ch.prim_here      <= face_on_bus.prim_here;
                    face_ch.prim_above     <= face_on_bus.prim_above;
                    face_ch.rho_below      <= face_on_bus.rho_below;
                    face_ch.rho_here       <= face_on_bus.rho_here;
                    face_ch.mu_below       <= face_on_bus.mu_below;
                    face_ch.mu_here        <= face_on_bus.mu_here;
                    face_ch.map_factor     <= face_on_bus.map_factor;
                    face_ch.valid          <= 1'b1;
                    send_gap = draw_idle(sender_calm);
                end
            end
        end
    end

    // Flux monitor: checks each accepted result, then stalls for a random count.
    always @(posedge clk or negedge rst_n)
    begin
        flux_t want;
        if (!rst_n)
        begin
            flux_ch.ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (flux_ch.valid && flux_ch.ready)
            begin
                if (flux_expected.size() == 0)
                begin
                    $error("unexpected result: flux %0d saturated %0b",
                           flux_ch.flux, flux_ch.saturated);
                    mismatches++;
                end
                else
                begin
                    want = flux_expected.pop_front();
                    if (flux_ch.flux !== want.flux)
                    begin
                        $error("flux: expected %0d, actual %0d", want.flux, flux_ch.flux);
                        mismatches++;
                    end
                    if (flux_ch.saturated !== want.saturated)
                    begin
                        $error("saturated: expected %0b, actual %0b",
                               want.saturated, flux_ch.saturated);
                        mismatches++;
                    end
                end
                recv_stall = draw_idle(receiver_calm);
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                flux_ch.ready <= 1'b0;
            end
            else
                flux_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (face_ch.valid && face_ch.ready) || (flux_ch.valid && flux_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("diffusive_face_flux_tb: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int unsigned phase_no;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_DENSITY_MODE;
        cfg_wdata = '0;
        face_ch.valid = 1'b0;
        face_ch.direction = DIR_X;
        face_ch.quantity_class = CLS_THETA;
        face_ch.boundary_case = BND_INTERIOR;
        face_ch.prim_below = '0;
        face_ch.prim_here = '0;
        face_ch.prim_above = '0;
        face_ch.rho_below = '0;
        face_ch.rho_here = '0;
        face_ch.mu_below = '0;
        face_ch.mu_here = '0;
        face_ch.map_factor = '0;
        flux_ch.ready = 1'b0;
        quiet_cycles = 0;
        mismatches = 0;
        sender_calm = 1'b0;
        receiver_calm = 1'b0;
        coeffs = '{density_mode: 1'b0, turbulence_on: 1'b0, alpha_theta: '0,
                   alpha_scalar: '0, inv_dx: ONE_Q, inv_dy: ONE_Q, inv_dz: ONE_Q};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Registers at their reset values.
        @(negedge clk);
        repeat (10) faces_pending.push_back(random_face());
        wait_idle();

        load_coeffs(1'b1, 1'b1, 31'h18000, 31'h4000, 31'h20000, 31'h8000, 31'h40000);
        add_face(DIR_X, CLS_THETA, BND_INTERIOR, 32'sh10000, 32'sh30000, 32'sh0,
                 ONE_Q, ONE_Q, 31'h8000, 31'h8000, ONE_Q);
        add_face(DIR_Y, CLS_SCALAR, BND_INTERIOR, 32'sh50000, 32'sh28000, 32'sh0,
                 31'h8000, 31'h18000, 31'h4000, 31'h0, 31'h20000);
        add_face(DIR_Z, CLS_TKE, BND_INTERIOR, -32'sh20000, 32'sh10000, 32'sh0,
                 ONE_Q, ONE_Q, 31'h30000, ONE_Q, ONE_Q);
        add_face(DIR_Z, CLS_THETA, BND_LOW, 32'sh10000, 32'sh20000, 32'sh40000,
                 ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q);
        add_face(DIR_Z, CLS_SCALAR, BND_HIGH, 32'sh10000, 32'sh20000, 32'sh40000,
                 ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q);
        // Boundary codes on horizontal faces fall back to the plain difference.
        add_face(DIR_X, CLS_THETA, BND_LOW, 32'sh10000, 32'sh20000, 32'sh40000,
                 ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q);
        add_face(DIR_Y, CLS_SCALAR, BND_HIGH, 32'sh10000, 32'sh20000, 32'sh40000,
                 ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q);
        add_face(SEL_UNUSED, CLS_THETA, BND_LOW, 32'sh10000, 32'sh20000, 32'sh40000,
                 ONE_Q, ONE_Q, ONE_Q, ONE_Q, 31'h20000);
        add_face(DIR_X, SEL_UNUSED, BND_INTERIOR, 32'sh10000, 32'sh20000, 32'sh0,
                 ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q);
        add_face(DIR_Z, CLS_THETA, SEL_UNUSED, 32'sh10000, 32'sh20000, 32'sh40000,
                 ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q);
        add_face(DIR_X, CLS_THETA, BND_INTERIOR, WMIN_MAG, WMAX, 32'sh0,
                 ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q);
        add_face(DIR_X, CLS_THETA, BND_INTERIOR, WMAX, WMIN_MAG, 32'sh0,
                 ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q);
        add_face(DIR_Z, CLS_THETA, BND_LOW, WMIN_MAG, WMAX, WMIN_MAG,
                 ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q);
        add_face(DIR_Z, CLS_THETA, BND_HIGH, WMIN_MAG, WMAX, WMIN_MAG,
                 ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q);
        add_face(DIR_Z, CLS_SCALAR, BND_LOW, WMAX, WMIN_MAG, WMAX,
                 ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q);
        add_face(DIR_Z, CLS_THETA, BND_INTERIOR, 32'sh0, 32'sh100, 32'sh0,
                 {POS_W{1'b1}}, {POS_W{1'b1}}, {POS_W{1'b1}}, {POS_W{1'b1}}, ONE_Q);
        add_face(DIR_Y, CLS_SCALAR, BND_INTERIOR, 32'sh0, 32'sh10000, 32'sh0,
                 ONE_Q, ONE_Q, ONE_Q, ONE_Q, {POS_W{1'b1}});
        add_face(DIR_X, CLS_THETA, BND_INTERIOR, 32'sh0, 32'sh10000, 32'sh0,
                 ONE_Q, ONE_Q, ONE_Q, ONE_Q, 31'h0);
        add_face(DIR_X, CLS_THETA, BND_INTERIOR, 32'sh0, 32'sh0, 32'sh0,
                 31'h0, 31'h0, 31'h0, 31'h0, 31'h0);
        // Tiny negative products must round toward zero, not toward minus infinity.
        add_face(DIR_Z, CLS_THETA, BND_INTERIOR, 32'sh0, -32'sh1, 32'sh0,
                 ONE_Q, ONE_Q, 31'h0, 31'h0, ONE_Q);
        add_face(DIR_Z, CLS_THETA, BND_LOW, 32'sh0, 32'sh0, 32'sh1,
                 ONE_Q, ONE_Q, 31'h0, 31'h0, ONE_Q);
        add_face(DIR_Z, CLS_THETA, BND_LOW, 32'sh0, 32'sh0, 32'sh2,
                 ONE_Q, ONE_Q, 31'h0, 31'h0, ONE_Q);
        add_face(DIR_Z, CLS_THETA, BND_HIGH, 32'sh0, 32'sh0, 32'sh2,
                 ONE_Q, ONE_Q, 31'h0, 31'h0, ONE_Q);
        wait_idle();

        for (phase_no = 0; phase_no < PHASES; phase_no++)
        begin
            if (phase_no == 0)
                load_coeffs(1'b1, 1'b1, {POS_W{1'b1}}, {POS_W{1'b1}}, {POS_W{1'b1}},
                            {POS_W{1'b1}}, {POS_W{1'b1}});
            else if (phase_no == 1)
                load_coeffs(1'b0, 1'b0, '0, '0, '0, '0, '0);
            else
                load_coeffs(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), pick_pos(),
                            pick_pos(), pick_pos(), pick_pos(), pick_pos());
            sender_calm   = ($urandom_range(3, 0) == 0);
            receiver_calm = ($urandom_range(3, 0) == 0);
            repeat (FACES_PER_PHASE) faces_pending.push_back(random_face());
            wait_idle();
        end

        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("diffusive_face_flux_tb: done, clean");
        else
            $display("diffusive_face_flux_tb: done, errors");
        $finish;
    end

endmodule
